@@ hdl/mds_pkg.sv @@
// Shared types, constants and the division step for the saturating multiply-divide block.
`default_nettype none
package mds_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FIELD_BITS = 32;
    localparam int PROD_BITS  = 2 * WORD_BITS;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic [FIELD_BITS-1:0] multiplicand;
        logic [FIELD_BITS-1:0] multiplier;
        logic [FIELD_BITS-1:0] divisor;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] quotient;
        t_status               status;
    } t_out_item;

    typedef struct packed {
        logic                 valid;
        t_status              status;
        logic [WORD_BITS:0]   rem;
        logic [WORD_BITS-1:0] lo;
        logic [WORD_BITS-1:0] q;
        logic [WORD_BITS-1:0] d;
    } t_div_stage;

    function automatic t_div_stage div_step(input t_div_stage s);
        t_div_stage         r;
        logic [WORD_BITS:0] sh;
        logic [WORD_BITS:0] dx;
        r  = s;
        sh = {s.rem[WORD_BITS-1:0], s.lo[WORD_BITS-1]};
        dx = {1'b0, s.d};
        r.lo = {s.lo[WORD_BITS-2:0], 1'b0};
        if (sh >= dx) begin
            r.rem = sh - dx;
            r.q   = {s.q[WORD_BITS-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.q   = {s.q[WORD_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/mds_div_pipe.sv @@
// Restoring division array: one quotient bit per register stage.
`default_nettype none
module mds_div_pipe (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire mds_pkg::t_div_stage i_stg,
    output mds_pkg::t_div_stage      o_stg
);
    import mds_pkg::*;

    t_div_stage r_stg [WORD_BITS];
    t_div_stage n_stg [WORD_BITS];

    always_comb begin
        n_stg[0] = div_step(i_stg);
        for (int k = 1; k < WORD_BITS; k++) begin
            n_stg[k] = div_step(r_stg[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WORD_BITS; k++) begin
                r_stg[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < WORD_BITS; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_stg = r_stg[WORD_BITS-1];

endmodule
`default_nettype wire

@@ hdl/mul_div_saturating_32_top.sv @@
// Top level of the saturating multiply-then-divide pipeline.
// Path: input register, multiplier, setup compare, 32 division stages, output register.
// Throughput: one transaction per cycle while the skid register is empty;
//   a skid register holds one result under stall.
// Reset: synchronous active low; clears all valid bits, payload registers are not reset.
`default_nettype none
module mul_div_saturating_32_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire mds_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output mds_pkg::t_out_item      o_out
);
    import mds_pkg::*;

    logic                 en;
    logic                 out_free;

    logic                 r_a_vld;
    logic [WORD_BITS-1:0] r_a_mcand;
    logic [WORD_BITS-1:0] r_a_mplier;
    logic [WORD_BITS-1:0] r_a_div;

    logic                 r_b_vld;
    logic [PROD_BITS-1:0] r_b_prod;
    logic [WORD_BITS-1:0] r_b_div;

    t_div_stage           r_c;
    t_div_stage           n_c;
    t_div_stage           pipe_out;

    t_out_item            last_item;
    t_out_item            r_out;
    logic                 r_out_vld;
    t_out_item            r_skid;
    logic                 r_skid_vld;

    logic [WORD_BITS-1:0] hi;

    assign en         = !r_skid_vld;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c.valid <= 1'b0;
        end else if (en) begin
            r_a_vld    <= i_in_valid;
            r_a_mcand  <= i_in.multiplicand[WORD_BITS-1:0];
            r_a_mplier <= i_in.multiplier[WORD_BITS-1:0];
            r_a_div    <= i_in.divisor[WORD_BITS-1:0];
            r_b_vld    <= r_a_vld;
            r_b_prod   <= {{WORD_BITS{1'b0}}, r_a_mcand} * {{WORD_BITS{1'b0}}, r_a_mplier};
            r_b_div    <= r_a_div;
            r_c        <= n_c;
        end
    end

    assign hi = r_b_prod[PROD_BITS-1:WORD_BITS];

    always_comb begin
        n_c.valid = r_b_vld;
        n_c.rem   = {1'b0, hi};
        n_c.lo    = r_b_prod[WORD_BITS-1:0];
        n_c.q     = '0;
        n_c.d     = r_b_div;
        if (r_b_div == '0) begin
            n_c.status = ST_DIV0;
        end else if (hi >= r_b_div) begin
            n_c.status = ST_SAT;
        end else begin
            n_c.status = ST_OK;
        end
    end

    mds_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stg   (r_c),
        .o_stg   (pipe_out)
    );

    always_comb begin
        last_item.status = pipe_out.status;
        case (pipe_out.status)
            ST_OK:   last_item.quotient = FIELD_BITS'(pipe_out.q);
            ST_SAT:  last_item.quotient = FIELD_BITS'({WORD_BITS{1'b1}});
            default: last_item.quotient = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_free) begin
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (out_free) begin
            r_out     <= last_item;
            r_out_vld <= pipe_out.valid;
        end else if (pipe_out.valid) begin
            r_skid     <= last_item;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule
`default_nettype wire

@@ hdl/mds_checker.sv @@
// Port-level assertions for the saturating multiply-divide top level, with its bind.
`default_nettype none
module mds_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire                     o_in_stall,
    input wire mds_pkg::t_in_item  i_in,
    input wire                     o_out_valid,
    input wire                     i_out_stall,
    input wire mds_pkg::t_out_item o_out
);
    import mds_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled output transaction changed");

    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in)))
        else $error("stalled input transaction changed");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_DIV0) |-> (o_out.quotient == '0))
        else $error("zero divisor result not zero");

    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_SAT)
        |-> (o_out.quotient == FIELD_BITS'({WORD_BITS{1'b1}})))
        else $error("saturated result not all ones");

endmodule

bind mul_div_saturating_32_top mds_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the saturating multiply-then-divide pipeline.
`default_nettype none
module tb;
    import mds_pkg::*;

    localparam int N_RANDOM       = 1730;
    localparam int N_DIRECTED     = 21;
    localparam int HOLD_AT_ITEM   = 700;
    localparam int DRAIN_AT_ITEM  = 1300;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTS     = 60;

    typedef struct packed {
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        logic [FIELD_BITS-1:0] d;
        logic                  has_q;
        logic [FIELD_BITS-1:0] q;
        t_status               st;
    } t_mul_case;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    t_out_item expected_results[$];
    int        mismatch_count;
    bit        hold_req;
    t_mul_case dir_cases [N_DIRECTED];
    t_out_item seen_exp;

    mul_div_saturating_32_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item predict_quotient(input t_in_item x);
        t_out_item   r;
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        logic [63:0] prod;
        logic [63:0] hi;
        logic [63:0] q;
        mask = (64'd1 << WORD_BITS) - 64'd1;
        a    = {32'd0, x.multiplicand} & mask;
        b    = {32'd0, x.multiplier} & mask;
        d    = {32'd0, x.divisor} & mask;
        prod = a * b;
        hi   = (prod >> WORD_BITS) & mask;
        if (d == 64'd0) begin
            q        = 64'd0;
            r.status = ST_DIV0;
        end else if (hi >= d) begin
            q        = mask;
            r.status = ST_SAT;
        end else begin
            q        = prod / d;
            r.status = ST_OK;
        end
        r.quotient = q[FIELD_BITS-1:0];
        return r;
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand_operand();
        logic [FIELD_BITS-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 31);
            1: v = v >> $urandom_range(16, 31);
            2: v = {FIELD_BITS{1'b1}} >> $urandom_range(0, 3);
            3: v = 32'd1 << $urandom_range(0, 31);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand_divisor();
        logic [FIELD_BITS-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 15))
            0: v = '0;
            1, 2: v = v >> $urandom_range(20, 31);
            3, 4: v = v >> $urandom_range(1, 19);
            5: v = {FIELD_BITS{1'b1}} - $urandom_range(0, 3);
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic send_transaction(input t_in_item item, input t_out_item exp_item);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(exp_item);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result q=%h st=%0d",
                                          o_out.quotient, o_out.status));
            end else begin
                seen_exp = expected_results.pop_front();
                if (o_out.quotient !== seen_exp.quotient)
                    report_mismatch($sformatf("quotient %h, expected %h",
                                              o_out.quotient, seen_exp.quotient));
                if (o_out.status !== seen_exp.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_out.status, seen_exp.status));
            end
        end
    end

    initial begin
        int hold_left;
        int phase_left;
        int stall_pct;
        hold_left   = 0;
        phase_left  = 0;
        stall_pct   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 120);
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 20;
                    3: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            phase_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_in_item  item;
        t_out_item exp_item;
        int        burst_left;
        int        gap;
        mismatch_count = 0;
        hold_req       = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        burst_left     = 0;

        dir_cases = '{
            '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, ST_DIV0},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000, ST_DIV0},
            '{32'h00000000, 32'h00000000, 32'h00000001, 1'b1, 32'h00000000, ST_OK},
            '{32'h00000001, 32'h00000001, 32'h00000001, 1'b1, 32'h00000001, ST_OK},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, ST_OK},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 1'b1, 32'hFFFFFFFF, ST_SAT},
            '{32'h00010000, 32'h00010000, 32'h00000001, 1'b1, 32'hFFFFFFFF, ST_SAT},
            '{32'h00010000, 32'h00010000, 32'h00000002, 1'b1, 32'h80000000, ST_OK},
            '{32'hFFFFFFFF, 32'h00000002, 32'h00000001, 1'b1, 32'hFFFFFFFF, ST_SAT},
            '{32'hFFFFFFFF, 32'h00000002, 32'h00000002, 1'b1, 32'hFFFFFFFF, ST_OK},
            '{32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, ST_OK},
            '{32'h00000000, 32'hFFFFFFFF, 32'h00000001, 1'b1, 32'h00000000, ST_OK},
            '{32'h80000000, 32'h00000002, 32'h00000001, 1'b1, 32'hFFFFFFFF, ST_SAT},
            '{32'h7FFFFFFF, 32'h00000002, 32'h00000001, 1'b1, 32'hFFFFFFFE, ST_OK},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, 32'hFFFFFFFF, ST_SAT},
            '{32'h00000001, 32'hFFFFFFFF, 32'h80000000, 1'b1, 32'h00000001, ST_OK},
            '{32'h12345678, 32'h9ABCDEF0, 32'h00000007, 1'b0, 32'h0, ST_OK},
            '{32'hDEADBEEF, 32'hCAFEBABE, 32'hFFFFFFFE, 1'b0, 32'h0, ST_OK},
            '{32'h0000FFFF, 32'h0000FFFF, 32'h00000003, 1'b0, 32'h0, ST_OK},
            '{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAB, 1'b0, 32'h0, ST_OK},
            '{32'h80000000, 32'h80000000, 32'h40000001, 1'b0, 32'h0, ST_OK}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            item.multiplicand = dir_cases[i].a;
            item.multiplier   = dir_cases[i].b;
            item.divisor      = dir_cases[i].d;
            if (dir_cases[i].has_q) begin
                exp_item.quotient = dir_cases[i].q;
                exp_item.status   = dir_cases[i].st;
            end else begin
                exp_item = predict_quotient(item);
            end
            send_transaction(item, exp_item);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == HOLD_AT_ITEM)
                hold_req = 1'b1;
            if (i == DRAIN_AT_ITEM) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge i_clk);
            end
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            burst_left--;
            item.multiplicand = rand_operand();
            item.multiplier   = rand_operand();
            item.divisor      = rand_divisor();
            send_transaction(item, predict_quotient(item));
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
